/* design/sbus_frame_to_radio_packet_top_defines.svh */
// Assertion macros for the checker file of this block.
`ifndef SBUS_FRAME_TO_RADIO_PACKET_TOP_DEFINES_SVH
`define SBUS_FRAME_TO_RADIO_PACKET_TOP_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define SBUSRP_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sbusrp check failed in the same cycle");

// The condition must hold in the cycle after the trigger.
`define SBUSRP_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sbusrp check failed in the next cycle");

`endif

/* design/sbusrp_pkg.sv */
package sbusrp_pkg;

  localparam int FRAME_DEPTH = 25;
  localparam int POS_W       = 5;
  localparam int IDX_W       = 5;
  localparam int CHAN_W      = 11;
  localparam int ACC_W       = 18;
  localparam int CNT_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  typedef logic [7:0]            byte_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CHAN_W-1:0]     chan_t;
  typedef logic [3:0]            rf_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam byte_t START_BYTE = 8'h0F;
  localparam byte_t END_BYTE   = 8'h00;

  // Frame positions.
  localparam pos_t SW_FIRST_POS = 5'd12;
  localparam pos_t FLAG_POS     = 5'd23;
  localparam pos_t LAST_POS     = 5'd24;

  // Packet positions.
  localparam idx_t CHAN_LAST_IDX = 5'd10;
  localparam idx_t SW_IDX        = 5'd11;
  localparam idx_t FLAG_IDX      = 5'd12;
  localparam idx_t TAG_IDX       = 5'd13;
  localparam idx_t LAST_IDX      = 5'd17;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_SWITCH_THRESHOLD = 2'd0;
  localparam cfg_idx_t CFG_RF_CHANNEL       = 2'd1;
  localparam cfg_idx_t CFG_LINK_TAG         = 2'd2;

  localparam chan_t     THRESHOLD_RESET = 11'd905;
  localparam rf_t       RF_RESET        = 4'd0;
  localparam cfg_data_t TAG_RESET       = 32'h4F4C4548;

  typedef struct packed {
    logic clear;
    logic push;
  } acc_ctl_t;

endpackage

/* design/sbusrp_switch_acc.sv */
module sbusrp_switch_acc (
  input  logic                clk,
  input  logic                rst,
  input  sbusrp_pkg::acc_ctl_t ctl,
  input  sbusrp_pkg::byte_t   data,
  input  sbusrp_pkg::chan_t   threshold,
  output sbusrp_pkg::byte_t   sw_byte
);
  import sbusrp_pkg::*;

  localparam logic [CNT_W-1:0] BYTE_BITS = CNT_W'(8);
  localparam logic [CNT_W-1:0] CHAN_BITS = CNT_W'(CHAN_W);

  logic [ACC_W-1:0] acc;
  logic [CNT_W-1:0] count;
  logic [2:0]       chan;
  byte_t            sw;
  logic [ACC_W-1:0] sum;
  logic [CNT_W-1:0] total;
  logic             take;

  // Frame bytes enter at the top of the bit window; a channel leaves from
  // the bottom as soon as eleven bits are present.
  always_comb begin
    sum   = acc | (ACC_W'(data) << count);
    total = count + BYTE_BITS;
    take  = (total >= CHAN_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      acc   <= '0;
      count <= '0;
      chan  <= '0;
      sw    <= '0;
    end else if (ctl.push) begin
      if (take) begin
        if (sum[CHAN_W-1:0] > threshold) begin
          sw[chan] <= 1'b1;
        end
        acc   <= sum >> CHAN_W;
        count <= total - CHAN_BITS;
        chan  <= chan + 3'd1;
      end else begin
        acc   <= sum;
        count <= total;
      end
    end
  end

  assign sw_byte = sw;

endmodule

/* design/sbus_frame_to_radio_packet_top.sv */
// Channel   Handshake              Payload
// input     in_valid / in_stall    rx_byte
// output    out_valid / out_stall  pkt_byte, pkt_index, pkt_last
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A byte that does not complete a frame is taken without holding off input.
// A completed frame holds off input while it is scanned and drained: 12 memory
// reads scan the switch channels, then each of packet bytes 0 to 10 takes a read
// and a transfer, and bytes 11 to 17 come from registers at one per cycle.
// Stalls on the output lengthen the drain cycle for cycle; cfg_ready is always high.
// Reset (rst, synchronous) returns the frame search to the start byte.
module sbus_frame_to_radio_packet_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sbusrp_pkg::byte_t     rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sbusrp_pkg::byte_t     pkt_byte,
  output sbusrp_pkg::idx_t      pkt_index,
  output logic                  pkt_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  sbusrp_pkg::cfg_idx_t  cfg_index,
  input  sbusrp_pkg::cfg_data_t cfg_data
);
  import sbusrp_pkg::*;

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_SCAN     = 2'd1;
  localparam logic [1:0] ST_EMIT_MEM = 2'd2;
  localparam logic [1:0] ST_EMIT_REG = 2'd3;

  logic [1:0] state;
  pos_t       position;
  pos_t       scan_addr;
  idx_t       emit_idx;
  logic       scan_land;
  logic       scan_land_last;
  logic       rd_pend;
  logic [1:0] flags;
  chan_t      threshold;
  rf_t        rf_channel;
  cfg_data_t  link_tag;

  byte_t      frame_mem [FRAME_DEPTH];
  byte_t      rd_data;

  logic       in_xfer;
  logic       out_free;
  logic       out_load;
  logic       frame_done;
  logic       scan_issue;
  logic       emit_issue;
  logic       rd_en;
  pos_t       rd_addr;
  byte_t      reg_byte;
  logic [1:0] tag_sel;
  acc_ctl_t   acc_ctl;
  byte_t      sw_byte;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = ((state == ST_EMIT_MEM) && rd_pend) ||
                     ((state == ST_EMIT_REG) && out_free);
  assign frame_done = in_xfer && (position == LAST_POS) && (rx_byte == END_BYTE);

  assign scan_issue = (state == ST_SCAN) && (scan_addr <= FLAG_POS);
  assign emit_issue = (state == ST_EMIT_MEM) && !rd_pend && out_free;
  assign rd_en      = scan_issue || emit_issue;
  assign rd_addr    = scan_issue ? scan_addr : pos_t'(emit_idx + IDX_W'(1));

  assign acc_ctl.clear = frame_done;
  assign acc_ctl.push  = scan_land;

  sbusrp_switch_acc u_switch_acc (
    .clk       (clk),
    .rst       (rst),
    .ctl       (acc_ctl),
    .data      (rd_data),
    .threshold (threshold),
    .sw_byte   (sw_byte)
  );

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      frame_mem[position] <= rx_byte;
    end
    if (rd_en) begin
      rd_data <= frame_mem[rd_addr];
    end
  end

  always_comb begin
    tag_sel  = 2'(emit_idx - TAG_IDX);
    reg_byte = '0;
    if (emit_idx == SW_IDX) begin
      reg_byte = sw_byte;
    end else if (emit_idx == FLAG_IDX) begin
      reg_byte = {rf_channel, 2'b00, flags};
    end else if ((emit_idx >= TAG_IDX) && (emit_idx < LAST_IDX)) begin
      case (tag_sel)
        2'd0:    reg_byte = link_tag[7:0];
        2'd1:    reg_byte = link_tag[15:8];
        2'd2:    reg_byte = link_tag[23:16];
        2'd3:    reg_byte = link_tag[31:24];
        default: reg_byte = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= THRESHOLD_RESET;
      rf_channel <= RF_RESET;
      link_tag   <= TAG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SWITCH_THRESHOLD: threshold  <= cfg_data[CHAN_W-1:0];
        CFG_RF_CHANNEL:       rf_channel <= cfg_data[3:0];
        CFG_LINK_TAG:         link_tag   <= cfg_data;
        default:              ;
      endcase
    end
  end

  // Payload registers of the output stage, and the flag bits captured during the scan.
  always_ff @(posedge clk) begin
    if (emit_issue) begin
      pkt_index <= emit_idx;
      pkt_last  <= 1'b0;
    end
    if (rd_pend) begin
      pkt_byte <= rd_data;
    end
    if (state == ST_SCAN && scan_land_last) begin
      flags <= rd_data[1:0];
    end
    if (state == ST_EMIT_REG && out_free) begin
      pkt_byte  <= reg_byte;
      pkt_index <= emit_idx;
      pkt_last  <= (emit_idx == LAST_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      position       <= '0;
      scan_addr      <= '0;
      emit_idx       <= '0;
      scan_land      <= 1'b0;
      scan_land_last <= 1'b0;
      rd_pend        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      scan_land      <= scan_issue;
      scan_land_last <= scan_issue && (scan_addr == FLAG_POS);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (position == '0) begin
              if (rx_byte == START_BYTE) begin
                position <= pos_t'(1);
              end
            end else if (position == LAST_POS) begin
              position <= '0;
              if (frame_done) begin
                state     <= ST_SCAN;
                scan_addr <= SW_FIRST_POS;
              end
            end else begin
              position <= position + pos_t'(1);
            end
          end
        end
        ST_SCAN: begin
          if (scan_issue) begin
            scan_addr <= scan_addr + pos_t'(1);
          end
          if (scan_land_last) begin
            state    <= ST_EMIT_MEM;
            emit_idx <= '0;
          end
        end
        ST_EMIT_MEM: begin
          // One byte in flight: the read lands straight into the empty output stage.
          if (emit_issue) begin
            rd_pend  <= 1'b1;
            emit_idx <= emit_idx + idx_t'(1);
          end
          if (rd_pend) begin
            rd_pend <= 1'b0;
            if (pkt_index == CHAN_LAST_IDX) begin
              state <= ST_EMIT_REG;
            end
          end
        end
        ST_EMIT_REG: begin
          if (out_free) begin
            if (emit_idx == LAST_IDX) begin
              state <= ST_IDLE;
            end else begin
              emit_idx <= emit_idx + idx_t'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* design/sbusrp_checker.sv */
`include "sbus_frame_to_radio_packet_top_defines.svh"

module sbusrp_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input sbusrp_pkg::byte_t pkt_byte,
  input sbusrp_pkg::idx_t  pkt_index,
  input logic              pkt_last
);
  import sbusrp_pkg::*;

  // A stalled packet byte holds until it is taken.
  `SBUSRP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pkt_byte) && $stable(pkt_index) && $stable(pkt_last))

  // The last marker sits on the final packet position and nowhere else.
  `SBUSRP_ASSERT_IMP(a_last_pos, out_valid, pkt_last == (pkt_index == LAST_IDX))

  `SBUSRP_ASSERT_IMP(a_index_range, out_valid, pkt_index <= LAST_IDX)

  // While a packet drains, no new serial byte is taken.
  `SBUSRP_ASSERT_IMP(a_drain_stall, out_valid && !pkt_last, in_stall)

endmodule

bind sbus_frame_to_radio_packet_top sbusrp_checker u_sbusrp_checker (.*);

/* sim/sbus_frame_to_radio_packet_top_tb.sv */
module sbus_frame_to_radio_packet_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbusrp_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int PKT_LEN      = 18;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_GAP      = 60;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 20;
  localparam cfg_idx_t CFG_UNMAPPED = 2'd3;

  typedef struct {
    byte_t value;
    idx_t  index;
    logic  last;
  } pkt_beat_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  byte_t     rx_byte = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  byte_t     pkt_byte;
  idx_t      pkt_index;
  logic      pkt_last;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index = '0;
  cfg_data_t cfg_data = '0;

  // Shadow of the block: frame assembly state and the settings it was given.
  byte_t     frame_mem [FRAME_DEPTH];
  pos_t      frame_pos = '0;
  chan_t     threshold_q = THRESHOLD_RESET;
  rf_t       rf_q = RF_RESET;
  cfg_data_t tag_q = TAG_RESET;

  pkt_beat_t pending_pkt_q [$];

  int sender_idle_pct = 0;
  int stall_pct = 0;
  int busy_items = 0;
  int mismatch_count = 0;

  sbus_frame_to_radio_packet_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pkt_byte  (pkt_byte),
    .pkt_index (pkt_index),
    .pkt_last  (pkt_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // Builds the 18 packet bytes of a completed frame and queues them.
  task automatic queue_radio_packet();
    logic [87:0] sw_bits;
    byte_t       sw_flags;
    byte_t       pkt [PKT_LEN];
    pkt_beat_t   beat;
    sw_flags = '0;
    for (int j = 0; j < 11; j++) sw_bits[8*j +: 8] = frame_mem[SW_FIRST_POS + j];
    for (int i = 0; i <= CHAN_LAST_IDX; i++) pkt[i] = frame_mem[i + 1];
    for (int k = 0; k < 8; k++) begin
      if (sw_bits[11*k +: 11] > threshold_q) sw_flags[k] = 1'b1;
    end
    pkt[SW_IDX] = sw_flags;
    pkt[FLAG_IDX] = {rf_q, 2'b00, frame_mem[FLAG_POS][1:0]};
    for (int t = 0; t < 4; t++) pkt[TAG_IDX + t] = tag_q[8*t +: 8];
    pkt[LAST_IDX] = '0;
    for (int i = 0; i < PKT_LEN; i++) begin
      beat.value = pkt[i];
      beat.index = idx_t'(i);
      beat.last  = (idx_t'(i) == LAST_IDX);
      pending_pkt_q.push_back(beat);
    end
  endtask

  task automatic absorb_rx_byte(input byte_t b, output bit ignored);
    ignored = 1'b0;
    frame_mem[frame_pos] = b;
    if (frame_pos == '0 && b != START_BYTE) begin
      ignored = 1'b1;
    end else if (frame_pos == LAST_POS) begin
      frame_pos = '0;
      if (b == END_BYTE) queue_radio_packet();
    end else begin
      frame_pos = frame_pos + 1'b1;
    end
  endtask

  // Starts and ends at a falling edge; valid stays high so the next byte
  // can follow without a gap.
  task automatic send_byte(input byte_t b);
    int gap;
    bit ignored;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_rx_byte(b, ignored);
    if (!ignored) busy_items++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [87:0] lead, input logic [87:0] sw_bits,
                            input byte_t flags, input byte_t tail);
    send_byte(START_BYTE);
    for (int i = 0; i < 11; i++) send_byte(lead[8*i +: 8]);
    for (int j = 0; j < 11; j++) send_byte(sw_bits[8*j +: 8]);
    send_byte(flags);
    send_byte(tail);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input cfg_data_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SWITCH_THRESHOLD: threshold_q = data[CHAN_W-1:0];
      CFG_RF_CHANNEL:       rf_q = data[3:0];
      CFG_LINK_TAG:         tag_q = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Writes every register back to back, including the unmapped index.
  task automatic load_settings(input cfg_data_t thr_word, input cfg_data_t rf_word,
                               input cfg_data_t tag_word);
    cfg_write(CFG_SWITCH_THRESHOLD, thr_word);
    cfg_write(CFG_RF_CHANNEL, rf_word);
    cfg_write(CFG_LINK_TAG, tag_word);
    cfg_write(CFG_UNMAPPED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  // Frames that end badly produce nothing, so the block may still be busy
  // when the queue empties; give it time before touching the registers.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pkt_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [87:0] random_lead();
    logic [87:0] r;
    for (int i = 0; i < 11; i++) r[8*i +: 8] = byte_t'($urandom);
    return r;
  endfunction

  // Switch channels, a third of them within one step of the threshold.
  function automatic logic [87:0] random_switches();
    logic [87:0] r;
    chan_t v;
    for (int k = 0; k < 8; k++) begin
      if ($urandom_range(2) == 0) v = threshold_q + chan_t'($urandom_range(2)) - chan_t'(1);
      else v = chan_t'($urandom);
      r[11*k +: 11] = v;
    end
    return r;
  endfunction

  task automatic test_start_search();
    sender_idle_pct = 0;
    stall_pct = 0;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hF0);
    send_byte(8'h0E);
    send_byte(8'h1F);
    send_frame({11{8'hFF}}, {8{11'h7FF}}, 8'hFF, END_BYTE);
    send_frame('0, '0, 8'hFC, END_BYTE);
    wait_drained();
  endtask

  task automatic test_end_byte();
    sender_idle_pct = 27;
    stall_pct = 27;
    send_frame(random_lead(), random_switches(), byte_t'($urandom), 8'h01);
    // A start byte in the end position must not begin a new frame.
    send_frame(random_lead(), random_switches(), byte_t'($urandom), START_BYTE);
    send_frame(random_lead(), random_switches(), byte_t'($urandom), 8'h80);
    send_frame(random_lead(), random_switches(), byte_t'($urandom), END_BYTE);
    wait_drained();
  endtask

  task automatic test_switch_threshold();
    sender_idle_pct = 0;
    stall_pct = 0;
    load_settings(32'd0, 32'd15, 32'hFFFF_FFFF);
    send_frame(random_lead(),
               {11'd0, 11'd1, 11'd0, 11'd1, 11'd0, 11'd2047, 11'd1, 11'd0},
               8'h01, END_BYTE);
    wait_drained();
    load_settings(32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'h0000_0000);
    send_frame(random_lead(), {8{11'h7FF}}, 8'h02, END_BYTE);
    wait_drained();
    load_settings(32'd905, 32'd5, $urandom);
    send_frame(random_lead(),
               {11'd2047, 11'd0, 11'd906, 11'd905, 11'd904, 11'd906, 11'd905, 11'd904},
               8'h03, END_BYTE);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int target;
    int kind;
    cfg_data_t thr_word;
    cfg_data_t tag_word;
    for (int phase = 0; phase < 5; phase++) begin
      case ($urandom_range(3))
        0:       thr_word = '0;
        1:       thr_word = 32'h7FF;
        default: thr_word = $urandom;
      endcase
      if ($urandom_range(3) == 0) tag_word = $urandom_range(1) ? '1 : '0;
      else tag_word = $urandom;
      load_settings(thr_word, $urandom, tag_word);
      case (phase)
        1:       begin sender_idle_pct = 82; stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  stall_pct = 82; end
        3:       begin sender_idle_pct = 27; stall_pct = 27; end
        default: begin sender_idle_pct = 0;  stall_pct = 0;  end
      endcase
      target = busy_items + PHASE_ITEMS;
      while (busy_items < target) begin
        kind = $urandom_range(99);
        if (kind < 78) begin
          send_frame(random_lead(), random_switches(), byte_t'($urandom), END_BYTE);
        end else if (kind < 88) begin
          send_frame(random_lead(), random_switches(), byte_t'($urandom),
                     byte_t'($urandom_range(1, 255)));
        end else if (kind < 94) begin
          repeat ($urandom_range(1, 6)) send_byte(byte_t'($urandom));
        end else begin
          // Cut-off frame: the next bytes simply continue it.
          send_byte(START_BYTE);
          repeat ($urandom_range(1, 23)) send_byte(byte_t'($urandom));
        end
      end
      wait_drained();
    end
  endtask

  always @(posedge clk) begin
    pkt_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pkt_q.size() == 0) begin
        $display("%0t: unexpected packet byte: expected none, got byte %02h index %0d last %0b",
                 $time, pkt_byte, pkt_index, pkt_last);
        mismatch_count++;
      end else begin
        want = pending_pkt_q.pop_front();
        if (pkt_byte !== want.value) begin
          $display("%0t: pkt_byte mismatch at index %0d: expected %02h, got %02h",
                   $time, want.index, want.value, pkt_byte);
          mismatch_count++;
        end
        if (pkt_index !== want.index) begin
          $display("%0t: pkt_index mismatch: expected %0d, got %0d",
                   $time, want.index, pkt_index);
          mismatch_count++;
        end
        if (pkt_last !== want.last) begin
          $display("%0t: pkt_last mismatch at index %0d: expected %0b, got %0b",
                   $time, want.index, want.last, pkt_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_start_search();
    test_end_byte();
    test_switch_threshold();
    test_random_traffic();
    if (pending_pkt_q.size() != 0) begin
      $display("%0t: %0d packet bytes expected but never transferred",
               $time, pending_pkt_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
